>>> rtl/amcs_pkg.sv
// Shared types and constants for the agitating motor cycle sequencer.
package amcs_pkg;

  localparam int FUNC_W      = 4;
  localparam int SEC_W       = 16;
  localparam int DUTY_FLD_W  = 16;
  localparam int STATUS_W    = 2;
  localparam int RAMP_W      = 13;
  localparam int DUTY_W_DEF  = 16;

  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [SEC_W-1:0]      sec_t;
  typedef logic [DUTY_FLD_W-1:0] duty_fld_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [RAMP_W-1:0]     ramp_t;

  localparam func_t FUNC_TICK      = 4'd0;
  localparam func_t FUNC_RUN       = 4'd1;
  localparam func_t FUNC_RESUME    = 4'd2;
  localparam func_t FUNC_STOP      = 4'd3;
  localparam func_t FUNC_PAUSE     = 4'd4;
  localparam func_t FUNC_ABORT     = 4'd5;
  localparam func_t FUNC_SET_DUR   = 4'd6;
  localparam func_t FUNC_SET_SPEED = 4'd7;
  localparam func_t FUNC_SET_AGIT  = 4'd8;

  localparam status_t ST_STOPPED = 2'd0;
  localparam status_t ST_RUNNING = 2'd1;
  localparam status_t ST_PAUSED  = 2'd2;
  localparam status_t ST_READY   = 2'd3;

  localparam ramp_t RAMP_RESET = 13'd10;

endpackage

>>> rtl/amcs_if.sv
// Valid/ready channel interfaces for commands and status results.
interface amcs_cmd_if;
  import amcs_pkg::*;

  logic      valid;
  logic      ready;
  func_t     func;
  sec_t      run_seconds;
  duty_fld_t max_duty_in;
  sec_t      agitate_seconds;

  modport source (output valid, output func, output run_seconds, output max_duty_in,
                  output agitate_seconds, input ready);
  modport sink   (input valid, input func, input run_seconds, input max_duty_in,
                  input agitate_seconds, output ready);
endinterface

interface amcs_res_if;
  import amcs_pkg::*;

  logic      valid;
  logic      ready;
  duty_fld_t duty_out;
  logic      reverse_dir;
  status_t   state_code;
  sec_t      time_left;
  logic      report;
  logic      cycle_active;

  modport source (output valid, output duty_out, output reverse_dir, output state_code,
                  output time_left, output report, output cycle_active, input ready);
  modport sink   (input valid, input duty_out, input reverse_dir, input state_code,
                  input time_left, input report, input cycle_active, output ready);
endinterface

>>> rtl/agitating_motor_cycle_sequencer.sv
// Agitating motor cycle sequencer: every accepted transaction (a one-second tick
// or a command) yields exactly one status result. A transaction is captured in an
// input register, processed by combinational counter, compare and ramp logic that
// updates the cycle state, and lands in an output register; a new transaction is
// taken every cycle, limited only by the result side taking its results. ramp_step
// is written through cfg_we/cfg_wdata; the user must write it only while idle, and
// the block itself does not enforce this. A zero step behaves as one. Duty is held
// at DUTY_WIDTH bits, and larger targets saturate to the largest value of that width.
module agitating_motor_cycle_sequencer #(
  parameter int DUTY_WIDTH = amcs_pkg::DUTY_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  amcs_cmd_if.sink             in_ch,
  amcs_res_if.source           out_ch,
  input  logic                 cfg_we,
  input  amcs_pkg::ramp_t      cfg_wdata
);

  import amcs_pkg::*;

  localparam int CW = (DUTY_WIDTH > RAMP_W) ? DUTY_WIDTH : RAMP_W;
  localparam duty_fld_t DUTY_MAX = duty_fld_t'((32'd1 << DUTY_WIDTH) - 32'd1);

  typedef logic [DUTY_WIDTH-1:0] duty_t;
  typedef logic [CW-1:0]         cmp_t;

  // input stage
  logic      in_valid_r;
  func_t     func_r;
  sec_t      run_r;
  duty_fld_t maxd_r;
  sec_t      agit_r;

  // output stage
  logic      out_valid_r;
  duty_fld_t o_duty_r;
  logic      o_dir_r;
  status_t   o_state_r;
  sec_t      o_time_r;
  logic      o_report_r;
  logic      o_active_r;

  // cycle state
  ramp_t   ramp_step_r;
  logic    active_r, keep_going_r, rev_pending_r, direction_r;
  duty_t   duty_now_r, duty_goal_r, duty_saved_r;
  sec_t    seconds_left_r, rev_count_r, agit_period_r;
  status_t status_r;

  logic    active_nxt, keep_going_nxt, rev_pending_nxt, direction_nxt;
  duty_t   duty_now_nxt, duty_goal_nxt, duty_saved_nxt;
  sec_t    seconds_left_nxt, rev_count_nxt, agit_period_nxt;
  status_t status_nxt;
  logic    report_nxt;

  logic    advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_comb begin
    duty_t goal_in;
    ramp_t step;
    cmp_t  diff;
    logic  in_cycle;
    logic  aborted;

    goal_in  = (maxd_r > DUTY_MAX) ? DUTY_MAX[DUTY_WIDTH-1:0] : maxd_r[DUTY_WIDTH-1:0];
    step     = (ramp_step_r == '0) ? ramp_t'(1) : ramp_step_r;
    diff     = '0;
    in_cycle = 1'b0;
    aborted  = 1'b0;

    active_nxt       = active_r;
    keep_going_nxt   = keep_going_r;
    rev_pending_nxt  = rev_pending_r;
    direction_nxt    = direction_r;
    duty_now_nxt     = duty_now_r;
    duty_goal_nxt    = duty_goal_r;
    duty_saved_nxt   = duty_saved_r;
    seconds_left_nxt = seconds_left_r;
    rev_count_nxt    = rev_count_r;
    agit_period_nxt  = agit_period_r;
    status_nxt       = status_r;
    report_nxt       = 1'b0;

    if (!active_r) begin
      unique case (func_r) inside
        FUNC_RUN, FUNC_RESUME: begin
          status_nxt = ST_RUNNING;
          if (func_r == FUNC_RUN) seconds_left_nxt = run_r;
          duty_goal_nxt   = goal_in;
          agit_period_nxt = agit_r;
          rev_count_nxt   = agit_r;
          duty_now_nxt    = '0;
          duty_saved_nxt  = '0;
          rev_pending_nxt = 1'b0;
          keep_going_nxt  = 1'b1;
          active_nxt      = 1'b1;
        end
        FUNC_STOP, FUNC_PAUSE, FUNC_ABORT, FUNC_SET_DUR, FUNC_SET_SPEED,
        FUNC_SET_AGIT: begin
          status_nxt = ST_READY;
          report_nxt = 1'b1;
        end
        default: ;
      endcase
    end else begin
      in_cycle = 1'b1;
      unique case (func_r)
        FUNC_TICK: begin
          if (seconds_left_nxt != '0) seconds_left_nxt = seconds_left_nxt - sec_t'(1);
          if (rev_count_nxt != '0) rev_count_nxt = rev_count_nxt - sec_t'(1);
          report_nxt = 1'b1;
        end
        FUNC_RUN, FUNC_RESUME: ;
        FUNC_STOP: begin
          status_nxt       = ST_STOPPED;
          seconds_left_nxt = '0;
          duty_goal_nxt    = '0;
          keep_going_nxt   = 1'b0;
        end
        FUNC_PAUSE: begin
          status_nxt     = ST_PAUSED;
          duty_goal_nxt  = '0;
          keep_going_nxt = 1'b0;
        end
        FUNC_ABORT: begin
          duty_now_nxt    = '0;
          active_nxt      = 1'b0;
          keep_going_nxt  = 1'b0;
          rev_pending_nxt = 1'b0;
          aborted         = 1'b1;
        end
        FUNC_SET_DUR:   seconds_left_nxt = run_r;
        FUNC_SET_SPEED: duty_goal_nxt = goal_in;
        FUNC_SET_AGIT: begin
          agit_period_nxt = agit_r;
          rev_count_nxt   = agit_r;
        end
        default: in_cycle = 1'b0;  // unknown codes leave everything alone
      endcase

      if (in_cycle && !aborted) begin
        if (seconds_left_nxt == '0) begin
          keep_going_nxt = 1'b0;
          duty_goal_nxt  = '0;
          status_nxt     = ST_STOPPED;
        end
        if (rev_count_nxt == '0) begin
          rev_pending_nxt = 1'b1;
          duty_saved_nxt  = duty_goal_nxt;
          duty_goal_nxt   = '0;
          rev_count_nxt   = agit_period_nxt;
        end
        // one ramp step, clamped at the goal
        if (duty_now_nxt < duty_goal_nxt) begin
          diff = cmp_t'(duty_goal_nxt - duty_now_nxt);
          duty_now_nxt = (diff > cmp_t'(step)) ?
                         duty_t'(cmp_t'(duty_now_nxt) + cmp_t'(step)) : duty_goal_nxt;
        end else if (duty_now_nxt > duty_goal_nxt) begin
          diff = cmp_t'(duty_now_nxt - duty_goal_nxt);
          duty_now_nxt = (diff > cmp_t'(step)) ?
                         duty_t'(cmp_t'(duty_now_nxt) - cmp_t'(step)) : duty_goal_nxt;
        end
        if (rev_pending_nxt && (duty_now_nxt <= duty_goal_nxt)) begin
          direction_nxt   = !direction_nxt;
          duty_goal_nxt   = duty_saved_nxt;
          rev_pending_nxt = 1'b0;
        end
        if (!keep_going_nxt && (duty_now_nxt == '0)) begin
          active_nxt      = 1'b0;
          rev_pending_nxt = 1'b0;
          report_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      ramp_step_r    <= RAMP_RESET;
      active_r       <= 1'b0;
      keep_going_r   <= 1'b0;
      rev_pending_r  <= 1'b0;
      direction_r    <= 1'b0;
      duty_now_r     <= '0;
      duty_goal_r    <= '0;
      duty_saved_r   <= '0;
      seconds_left_r <= '0;
      rev_count_r    <= '0;
      agit_period_r  <= '0;
      status_r       <= ST_STOPPED;
    end else begin
      if (cfg_we) ramp_step_r <= cfg_wdata;

      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        active_r       <= active_nxt;
        keep_going_r   <= keep_going_nxt;
        rev_pending_r  <= rev_pending_nxt;
        direction_r    <= direction_nxt;
        duty_now_r     <= duty_now_nxt;
        duty_goal_r    <= duty_goal_nxt;
        duty_saved_r   <= duty_saved_nxt;
        seconds_left_r <= seconds_left_nxt;
        rev_count_r    <= rev_count_nxt;
        agit_period_r  <= agit_period_nxt;
        status_r       <= status_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      run_r  <= in_ch.run_seconds;
      maxd_r <= in_ch.max_duty_in;
      agit_r <= in_ch.agitate_seconds;
    end
    if (advance) begin
      o_duty_r   <= duty_fld_t'(duty_now_nxt);
      o_dir_r    <= direction_nxt;
      o_state_r  <= status_nxt;
      o_time_r   <= seconds_left_nxt;
      o_report_r <= report_nxt;
      o_active_r <= active_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.duty_out     = o_duty_r;
  assign out_ch.reverse_dir  = o_dir_r;
  assign out_ch.state_code   = o_state_r;
  assign out_ch.time_left    = o_time_r;
  assign out_ch.report       = o_report_r;
  assign out_ch.cycle_active = o_active_r;

endmodule

>>> test/agitating_motor_cycle_sequencer_checker.sv
// Checker for the agitating motor cycle sequencer: predicts each status result and compares it.
module agitating_motor_cycle_sequencer_checker #(
  parameter int DUTY_WIDTH = amcs_pkg::DUTY_W_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  amcs_cmd_if             cmd_mon,
  amcs_res_if             res_mon,
  input  logic            cfg_we,
  input  amcs_pkg::ramp_t cfg_wdata,
  output int              mismatches,
  output int              pending
);

  import amcs_pkg::*;

  localparam int DUTY_MAX  = (1 << DUTY_WIDTH) - 1;

  typedef struct packed {
    duty_fld_t duty;
    logic      dir;
    status_t   st;
    sec_t      left;
    logic      rpt;
    logic      act;
  } motor_status_t;

  motor_status_t status_q[$];

  // predicted sequencer state
  logic      mc_active, mc_keep, mc_rev_pend, mc_dir;
  duty_fld_t mc_duty, mc_goal, mc_saved;
  sec_t      mc_secs, mc_rev_cnt, mc_period;
  status_t   mc_status;
  ramp_t     mc_ramp;

  initial mismatches = 0;

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic advance_motor(input func_t f, input sec_t run_s, input duty_fld_t duty_in,
                               input sec_t agit_s, output motor_status_t res);
    int        step;
    logic      rpt;
    duty_fld_t goal_in;
    rpt     = 1'b0;
    goal_in = (int'(duty_in) > DUTY_MAX) ? duty_fld_t'(DUTY_MAX) : duty_in;
    step    = (mc_ramp == '0) ? 1 : int'(mc_ramp);

    if (!mc_active) begin
      if (f == FUNC_RUN || f == FUNC_RESUME) begin
        mc_status = ST_RUNNING;
        if (f == FUNC_RUN)
          mc_secs = run_s;
        mc_goal     = goal_in;
        mc_period   = agit_s;
        mc_rev_cnt  = agit_s;
        mc_duty     = '0;
        mc_saved    = '0;
        mc_rev_pend = 1'b0;
        mc_keep     = 1'b1;
        mc_active   = 1'b1;
      end else if (f >= FUNC_STOP && f <= FUNC_SET_AGIT) begin
        mc_status = ST_READY;
        rpt       = 1'b1;
      end
    end else if (f == FUNC_ABORT) begin
      // hard stop: no ramp, no report, status untouched
      mc_duty     = '0;
      mc_active   = 1'b0;
      mc_keep     = 1'b0;
      mc_rev_pend = 1'b0;
    end else if (f <= FUNC_SET_AGIT) begin
      case (f)
        FUNC_TICK: begin
          if (mc_secs != 0) mc_secs--;
          if (mc_rev_cnt != 0) mc_rev_cnt--;
          rpt = 1'b1;
        end
        FUNC_STOP: begin
          mc_status = ST_STOPPED;
          mc_secs   = '0;
          mc_goal   = '0;
          mc_keep   = 1'b0;
        end
        FUNC_PAUSE: begin
          mc_status = ST_PAUSED;
          mc_goal   = '0;
          mc_keep   = 1'b0;
        end
        FUNC_SET_DUR:   mc_secs = run_s;
        FUNC_SET_SPEED: mc_goal = goal_in;
        FUNC_SET_AGIT: begin
          mc_period  = agit_s;
          mc_rev_cnt = agit_s;
        end
        default: ;
      endcase
      if (mc_secs == 0) begin
        mc_keep   = 1'b0;
        mc_goal   = '0;
        mc_status = ST_STOPPED;
      end
      if (mc_rev_cnt == 0) begin
        mc_rev_pend = 1'b1;
        mc_saved    = mc_goal;
        mc_goal     = '0;
        mc_rev_cnt  = mc_period;
      end
      // one ramp step, clamped at the goal
      if (mc_duty < mc_goal)
        mc_duty = (int'(mc_goal) - int'(mc_duty) > step) ?
                  duty_fld_t'(int'(mc_duty) + step) : mc_goal;
      else if (mc_duty > mc_goal)
        mc_duty = (int'(mc_duty) - int'(mc_goal) > step) ?
                  duty_fld_t'(int'(mc_duty) - step) : mc_goal;
      if (mc_rev_pend && mc_duty <= mc_goal) begin
        mc_dir      = ~mc_dir;
        mc_goal     = mc_saved;
        mc_rev_pend = 1'b0;
      end
      if (!mc_keep && mc_duty == 0) begin
        mc_active   = 1'b0;
        mc_rev_pend = 1'b0;
        rpt         = 1'b1;
      end
    end

    res.duty = mc_duty;
    res.dir  = mc_dir;
    res.st   = mc_status;
    res.left = mc_secs;
    res.rpt  = rpt;
    res.act  = mc_active;
  endtask

  always @(posedge clk) begin
    motor_status_t want;
    if (!rst_n) begin
      mc_active   = 1'b0;
      mc_keep     = 1'b0;
      mc_rev_pend = 1'b0;
      mc_dir      = 1'b0;
      mc_duty     = '0;
      mc_goal     = '0;
      mc_saved    = '0;
      mc_secs     = '0;
      mc_rev_cnt  = '0;
      mc_period   = '0;
      mc_status   = ST_STOPPED;
      mc_ramp     = RAMP_RESET;
      status_q.delete();
      pending     = 0;
    end else begin
      if (cfg_we)
        mc_ramp = cfg_wdata;
      if (cmd_mon.valid && cmd_mon.ready) begin
        advance_motor(cmd_mon.func, cmd_mon.run_seconds, cmd_mon.max_duty_in,
                      cmd_mon.agitate_seconds, want);
        status_q.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (status_q.size() == 0) begin
          log_mismatch("status transaction with no command waiting");
        end else begin
          want = status_q.pop_front();
          cmp_field("duty_out", 32'(res_mon.duty_out), 32'(want.duty));
          cmp_field("reverse_dir", 32'(res_mon.reverse_dir), 32'(want.dir));
          cmp_field("state_code", 32'(res_mon.state_code), 32'(want.st));
          cmp_field("time_left", 32'(res_mon.time_left), 32'(want.left));
          cmp_field("report", 32'(res_mon.report), 32'(want.rpt));
          cmp_field("cycle_active", 32'(res_mon.cycle_active), 32'(want.act));
        end
      end
      pending = status_q.size();
    end
  end

endmodule

>>> test/agitating_motor_cycle_sequencer_tb.sv
// Testbench top for the agitating motor cycle sequencer: stimulus, flow control and verdict.
module agitating_motor_cycle_sequencer_tb;
  import amcs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 130;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  ramp_t cfg_wdata;
  logic  hold_armed;
  int    mismatches;
  int    in_flight;
  int    cycle_cnt = 0;
  int    idle_pct;
  int    stall_pct;
  int    phase_items;
  int    cur_step;

  amcs_cmd_if cmd_ch ();
  amcs_res_if res_ch ();

  agitating_motor_cycle_sequencer #(.DUTY_WIDTH(DUTY_W_DEF)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  agitating_motor_cycle_sequencer_checker #(.DUTY_WIDTH(DUTY_W_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (cmd_ch),
    .res_mon    (res_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (in_flight)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off once armed
  initial begin
    int   hold_left;
    logic hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_cmd(input func_t f, input sec_t run_s, input duty_fld_t duty_in,
                          input sec_t agit_s);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.func            <= f;
    cmd_ch.run_seconds     <= run_s;
    cmd_ch.max_duty_in     <= duty_in;
    cmd_ch.agitate_seconds <= agit_s;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    phase_items++;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(input ramp_t val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_step  = (val == '0) ? 1 : int'(val);
  endtask

  function automatic sec_t rnd_secs();
    int p;
    p = $urandom_range(99);
    if (p < 80) return sec_t'($urandom_range(1, 25));
    if (p < 90) return '0;
    return sec_t'($urandom);
  endfunction

  function automatic sec_t rnd_agit();
    int p;
    p = $urandom_range(99);
    if (p < 70) return sec_t'($urandom_range(0, 6));
    if (p < 85) return '0;
    return sec_t'($urandom);
  endfunction

  // targets mostly within reach of fifteen ramp steps
  function automatic duty_fld_t rnd_duty();
    int p;
    int hi;
    p  = $urandom_range(99);
    hi = cur_step * 15;
    if (hi > 65535) hi = 65535;
    if (p < 80 || (cur_step < 64 && p < 96)) return duty_fld_t'($urandom_range(0, hi));
    if (p < 90) return '1;
    return duty_fld_t'($urandom);
  endfunction

  // usually a start command, a body of mostly ticks and settings, usually a closing command, then some noise
  task automatic play_session();
    int    len;
    int    pick;
    func_t f;
    if ($urandom_range(7) != 0)
      send_cmd(($urandom_range(3) == 0) ? FUNC_RESUME : FUNC_RUN, rnd_secs(), rnd_duty(),
               rnd_agit());
    len = $urandom_range(2, 30);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 55)      f = FUNC_TICK;
      else if (pick < 62) f = FUNC_SET_DUR;
      else if (pick < 69) f = FUNC_SET_SPEED;
      else if (pick < 76) f = FUNC_SET_AGIT;
      else if (pick < 80) f = FUNC_RUN;
      else if (pick < 82) f = FUNC_RESUME;
      else if (pick < 86) f = func_t'($urandom_range(9, 15));
      else if (pick < 90) f = FUNC_STOP;
      else if (pick < 94) f = FUNC_PAUSE;
      else if (pick < 96) f = FUNC_ABORT;
      else                f = FUNC_TICK;
      send_cmd(f, rnd_secs(), rnd_duty(), rnd_agit());
    end
    pick = $urandom_range(99);
    if (pick < 40)      send_cmd(FUNC_ABORT, sec_t'($urandom), duty_fld_t'($urandom), '0);
    else if (pick < 70) send_cmd(FUNC_STOP, '0, '0, sec_t'($urandom));
    else if (pick < 85) send_cmd(FUNC_PAUSE, sec_t'($urandom), '0, '0);
    repeat ($urandom_range(0, 3))
      send_cmd(func_t'($urandom_range(0, 15)), sec_t'($urandom), duty_fld_t'($urandom),
               sec_t'($urandom));
  endtask

  task automatic run_phase(input ramp_t val, input int idle, input int stall,
                           input logic pressure);
    write_step(val);
    idle_pct  = idle;
    stall_pct = stall;
    if (pressure)
      hold_armed <= 1'b1;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS)
      play_session();
  endtask

  initial begin
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= RAMP_RESET;
    hold_armed             <= 1'b0;
    cmd_ch.valid           <= 1'b0;
    cmd_ch.func            <= FUNC_TICK;
    cmd_ch.run_seconds     <= '0;
    cmd_ch.max_duty_in     <= '0;
    cmd_ch.agitate_seconds <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    cur_step  = int'(RAMP_RESET);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // outside a cycle: tick does nothing, commands answer ready, unknown codes ignored
    send_cmd(FUNC_TICK, '1, '1, '1);
    send_cmd(FUNC_STOP, '0, '0, '0);
    send_cmd(FUNC_PAUSE, '0, '0, '0);
    send_cmd(FUNC_ABORT, '0, '0, '0);
    send_cmd(FUNC_SET_DUR, '1, '0, '0);
    send_cmd(FUNC_SET_SPEED, '0, '1, '0);
    send_cmd(FUNC_SET_AGIT, '0, '0, '1);
    send_cmd(func_t'(9), '0, '0, '0);
    send_cmd(func_t'(15), '1, '1, '1);
    // zero reversal interval fires on each tick and known command but abort; run and resume ignored inside
    send_cmd(FUNC_RUN, 16'd3, 16'd25, '0);
    send_cmd(FUNC_TICK, '0, '0, '0);
    send_cmd(FUNC_RUN, '1, '1, '1);
    send_cmd(FUNC_RESUME, '0, '1, '0);
    send_cmd(func_t'(12), '1, '1, '1);
    send_cmd(FUNC_SET_SPEED, '0, '1, '0);
    send_cmd(FUNC_TICK, '0, '0, '0);
    send_cmd(FUNC_TICK, '0, '0, '0);
    send_cmd(FUNC_ABORT, '0, '0, '0);
    // resume keeps zero time left, so the cycle ends on the tick behind it
    send_cmd(FUNC_RESUME, 16'd9, 16'd40, 16'd2);
    send_cmd(FUNC_TICK, '0, '0, '0);
    // pause drops the target to zero and ends the cycle once the duty reaches it
    send_cmd(FUNC_RUN, '1, 16'd30, 16'd1);
    send_cmd(FUNC_SET_DUR, 16'd5, '0, '0);
    send_cmd(FUNC_PAUSE, '0, '0, '0);
    send_cmd(FUNC_TICK, '0, '0, '0);
    send_cmd(FUNC_STOP, '0, '0, '0);
    send_cmd(FUNC_ABORT, '0, '0, '0);
    send_cmd(FUNC_RUN, '0, '0, '0);
    send_cmd(FUNC_TICK, '0, '0, '0);

    run_phase(ramp_t'(1), 0, 0, 1'b0);
    run_phase(ramp_t'(4096), 50, 0, 1'b0);
    run_phase('0, 0, 50, 1'b0);
    run_phase(ramp_t'($urandom_range(1, 4096)), 8, 8, 1'b0);
    run_phase(ramp_t'($urandom_range(2, 64)), 0, 0, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> agitating_motor_cycle_sequencer.f
rtl/amcs_pkg.sv
rtl/amcs_if.sv
rtl/agitating_motor_cycle_sequencer.sv
test/agitating_motor_cycle_sequencer_checker.sv
test/agitating_motor_cycle_sequencer_tb.sv
